// ===== design/vtbs_pkg.sv =====
`default_nettype none

package vtbs_pkg;

    localparam int DEPTH_DEF       = 64;
    localparam int RANGE_MAX_DEF   = 31;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int HW_BITS = 5;
    localparam int PC_BITS = 4;
    localparam int HW_MAX  = 31;
    localparam int W_BITS  = 6;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HALF_WIDTH = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PASS_COUNT = 2'd1;

    localparam int PIPE_LAT   = 5;
    localparam int DRAIN_BITS = 3;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_RECIP,
        ST_PASS,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic valid;
        logic sub_en;
    } step_t;

endpackage

`default_nettype wire

// ===== design/vtbs_recip.sv =====
`default_nettype none

module vtbs_recip
    import vtbs_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    input  wire logic [W_BITS-1:0]                     w,
    output logic                                       busy,
    output logic [SAMPLE_BITS+2*W_BITS-2:0]            m
);

    localparam int K        = SAMPLE_BITS + 2 * W_BITS;
    localparam int M_BITS   = K - 1;
    localparam int CNT_BITS = $clog2(K + 2);

    logic                busy_reg, busy_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [W_BITS:0]     rem_reg, rem_next;
    logic [M_BITS-1:0]   q_reg, q_next;
    logic [W_BITS-1:0]   w_reg, w_next;
    logic [W_BITS:0]     rem_sh;
    logic                ge;

    // ceil(2^K / w), one quotient bit per cycle
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        w_next    = w_reg;
        rem_sh    = {rem_reg[W_BITS-1:0], (cnt_reg == '0)};
        ge        = (rem_sh >= {1'b0, w_reg});
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            q_next    = '0;
            w_next    = w;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? (rem_sh - {1'b0, w_reg}) : rem_sh;
            q_next   = {q_reg[M_BITS-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_BITS'(K))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        w_reg   <= w_next;
    end

    assign busy = busy_reg;
    assign m    = q_reg + M_BITS'(rem_reg != '0);

endmodule

`default_nettype wire

// ===== design/vtbs_lane.sv =====
`default_nettype none

module vtbs_lane
    import vtbs_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  clr,
    input  wire step_t                                 step,
    input  wire logic signed [SAMPLE_BITS-1:0]         add_data,
    input  wire logic signed [SAMPLE_BITS-1:0]         sub_data,
    input  wire logic [W_BITS-1:0]                     w,
    input  wire logic [SAMPLE_BITS+2*W_BITS-2:0]       m,
    output logic signed [SAMPLE_BITS-1:0]              q
);

    localparam int K      = SAMPLE_BITS + 2 * W_BITS;
    localparam int M_BITS = K - 1;
    localparam int N      = SAMPLE_BITS + W_BITS;
    localparam int P      = N + M_BITS;

    logic signed [N-1:0]           sum_reg, sum_next;
    logic [N-1:0]                  x_reg, x_next;
    logic                          neg1_reg, neg2_reg;
    logic [P-1:0]                  prod_reg, prod_next;
    logic signed [SAMPLE_BITS-1:0] q_reg, q_next;
    logic [N-1:0]                  neg_sum;
    logic [SAMPLE_BITS-1:0]        mag;

    always_comb
    begin
        sum_next = sum_reg;
        if (clr)
        begin
            sum_next = '0;
        end
        else if (step.valid)
        begin
            sum_next = sum_reg + N'(add_data) - (step.sub_en ? N'(sub_data) : N'(0));
        end
    end

    // floor(s / w) for s < 0 is -floor((|s| + w - 1) / w)
    always_comb
    begin
        neg_sum   = ~unsigned'(sum_reg) + 1'b1;
        x_next    = sum_reg[N-1] ? (neg_sum + N'(w) - 1'b1) : unsigned'(sum_reg);
        prod_next = P'(x_reg) * P'(m);
        mag       = prod_reg[K+SAMPLE_BITS-1:K];
        q_next    = neg2_reg ? signed'(~mag + 1'b1) : signed'(mag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        neg1_reg <= sum_reg[N-1];
        prod_reg <= prod_next;
        neg2_reg <= neg1_reg;
        q_reg    <= q_next;
    end

    assign q = q_reg;

endmodule

`default_nettype wire

// ===== design/vector_table_box_smoother.sv =====
`default_nettype none

// Channel  Direction  Handshake             Payload
// cfg      in         cfg_valid / cfg_ready cfg_index, cfg_data
// in       in         in_valid / in_stall   in_x, in_y, in_z, in_last
// out      out        out_valid / out_stall out_x, out_y, out_z, out_last
//
// Loading takes one item per cycle. The closing item starts a reciprocal
// setup, then each pass runs window steps (two read ports per bank, one step
// per cycle) and drains through the lane pipeline. Emission gives n items,
// one per cycle while the output is not stalled.
// No item is taken from the closing item until the last result has been
// read from the bank. Reset clears control only; the fill count bounds reads.
// A stalled output holds its register, and one more item waits in the bank
// read register.

module vector_table_box_smoother
    import vtbs_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int RANGE_MAX   = RANGE_MAX_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]       cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]      cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0] in_x,
    input  wire logic signed [SAMPLE_BITS-1:0] in_y,
    input  wire logic signed [SAMPLE_BITS-1:0] in_z,
    input  wire logic                          in_last,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0]      out_x,
    output logic signed [SAMPLE_BITS-1:0]      out_y,
    output logic signed [SAMPLE_BITS-1:0]      out_z,
    output logic                               out_last
);

    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS  = $clog2(DEPTH + 1);
    localparam int R_LIM     = (RANGE_MAX < HW_MAX) ? RANGE_MAX : HW_MAX;
    localparam int STEP_BITS = $clog2(2 * R_LIM + DEPTH);
    localparam int PTR_BITS  = STEP_BITS + 2;
    localparam int M_BITS    = SAMPLE_BITS + 2 * W_BITS - 1;
    localparam int WORD_BITS = 3 * SAMPLE_BITS;

    state_t state_reg, state_next;

    logic [HW_BITS-1:0]    hw_reg, hw_next;
    logic [PC_BITS-1:0]    pc_reg, pc_next;
    logic [CNT_BITS-1:0]   fill_reg, fill_next;
    logic [HW_BITS-1:0]    r_reg, r_next;
    logic [PC_BITS-1:0]    passes_reg, passes_next;
    logic                  src_reg, src_next;
    logic [STEP_BITS-1:0]  t_reg, t_next;
    logic [DRAIN_BITS-1:0] drain_reg, drain_next;
    logic [CNT_BITS-1:0]   e_reg, e_next;
    logic                  pend_reg, pend_next;
    logic                  pend_last_reg, pend_last_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_last_reg, out_last_next;
    logic [WORD_BITS-1:0]  out_word_reg;
    step_t                 step_reg, step_next;
    logic                  emit_pipe_reg [PIPE_LAT];
    logic [ADDR_BITS-1:0]  idx_pipe_reg  [PIPE_LAT];

    logic [WORD_BITS-1:0]  mem0_reg [DEPTH];
    logic [WORD_BITS-1:0]  mem1_reg [DEPTH];
    logic [WORD_BITS-1:0]  a0_reg, b0_reg, a1_reg, b1_reg;

    logic                  close_item;
    logic                  load_wr;
    logic                  issue;
    logic                  e_issue;
    logic                  rd_en;
    logic                  out_free;
    logic                  out_load;
    logic                  drain_end;
    logic                  clr;
    logic                  recip_busy;
    logic [M_BITS-1:0]     recip_m;
    logic [HW_BITS-1:0]    r_eff;
    logic [PC_BITS-1:0]    pc_eff;
    logic [W_BITS-1:0]     w_eff;
    logic [W_BITS-1:0]     w_cur;
    logic [STEP_BITS-1:0]  two_r;
    logic [STEP_BITS-1:0]  t_last;
    logic signed [PTR_BITS-1:0] p_add, p_sub;
    logic [ADDR_BITS-1:0]  rd_addr_a, rd_addr_b;
    logic [WORD_BITS-1:0]  rd_a, rd_b;
    logic                  wr0, wr1;
    logic [ADDR_BITS-1:0]  wr_addr;
    logic [WORD_BITS-1:0]  wr_data;
    logic [WORD_BITS-1:0]  merged;
    logic                  emit_in;
    logic [ADDR_BITS-1:0]  idx_in;
    logic signed [SAMPLE_BITS-1:0] q_x, q_y, q_z;

    function automatic logic [ADDR_BITS-1:0] clamp_idx(
        input logic signed [PTR_BITS-1:0] p,
        input logic [CNT_BITS-1:0]        n
    );
        logic signed [PTR_BITS-1:0] n_s;
        logic [ADDR_BITS-1:0]       res;
        n_s = signed'(PTR_BITS'(n));
        if (p < 0)
        begin
            res = '0;
        end
        else if (p >= n_s)
        begin
            res = ADDR_BITS'(n - 1'b1);
        end
        else
        begin
            res = ADDR_BITS'(p);
        end
        return res;
    endfunction

    // effective settings
    always_comb
    begin
        if (hw_reg == '0)
        begin
            r_eff = HW_BITS'(1);
        end
        else if (hw_reg > HW_BITS'(R_LIM))
        begin
            r_eff = HW_BITS'(R_LIM);
        end
        else
        begin
            r_eff = hw_reg;
        end
        pc_eff = (pc_reg == '0) ? PC_BITS'(1) : pc_reg;
        w_eff  = {r_eff, 1'b1};
        w_cur  = {r_reg, 1'b1};
    end

    assign close_item = (state_reg == ST_LOAD) && in_valid && in_last;
    assign drain_end  = (drain_reg == DRAIN_BITS'(PIPE_LAT - 1));
    assign two_r      = STEP_BITS'({r_reg, 1'b0});
    assign t_last     = two_r + STEP_BITS'(fill_reg) - 1'b1;
    assign out_free   = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (close_item)
                begin
                    state_next = ST_RECIP;
                end
            end
            ST_RECIP:
            begin
                if (!recip_busy)
                begin
                    state_next = ST_PASS;
                end
            end
            ST_PASS:
            begin
                if (t_reg == t_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (drain_end)
                begin
                    state_next = (passes_reg == PC_BITS'(1)) ? ST_EMIT : ST_PASS;
                end
            end
            ST_EMIT:
            begin
                if ((e_reg == fill_reg) && !pend_reg)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        in_stall = 1'b1;
        load_wr  = 1'b0;
        issue    = 1'b0;
        e_issue  = 1'b0;
        clr      = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                in_stall = 1'b0;
                load_wr  = in_valid && (fill_reg < CNT_BITS'(DEPTH));
            end
            ST_RECIP:
            begin
                clr = 1'b1;
            end
            ST_PASS:
            begin
                issue = 1'b1;
            end
            ST_DRAIN:
            begin
                clr = drain_end;
            end
            ST_EMIT:
            begin
                e_issue = (e_reg != fill_reg) && (!pend_reg || out_free);
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // window step addresses
    always_comb
    begin
        p_add     = signed'(PTR_BITS'(t_reg)) - signed'(PTR_BITS'(r_reg));
        p_sub     = p_add - signed'(PTR_BITS'(two_r)) - signed'(PTR_BITS'(1));
        rd_en     = issue || e_issue;
        rd_addr_a = issue ? clamp_idx(p_add, fill_reg) : e_reg[ADDR_BITS-1:0];
        rd_addr_b = clamp_idx(p_sub, fill_reg);
        emit_in   = issue && (t_reg >= two_r);
        idx_in    = ADDR_BITS'(t_reg - two_r);
        step_next.valid  = issue;
        step_next.sub_en = issue && (t_reg > two_r);
        rd_a = src_reg ? a1_reg : a0_reg;
        rd_b = src_reg ? b1_reg : b0_reg;
    end

    // merge of lane results and bank write port
    always_comb
    begin
        merged  = {q_z, q_y, q_x};
        wr_addr = load_wr ? fill_reg[ADDR_BITS-1:0] : idx_pipe_reg[PIPE_LAT-1];
        wr_data = load_wr ? {in_z, in_y, in_x} : merged;
        wr0     = (load_wr && !src_reg) || (emit_pipe_reg[PIPE_LAT-1] && src_reg);
        wr1     = (load_wr && src_reg) || (emit_pipe_reg[PIPE_LAT-1] && !src_reg);
    end

    // register next values
    always_comb
    begin
        hw_next        = hw_reg;
        pc_next        = pc_reg;
        fill_next      = fill_reg;
        r_next         = r_reg;
        passes_next    = passes_reg;
        src_next       = src_reg;
        t_next         = '0;
        drain_next     = '0;
        e_next         = '0;
        pend_next      = pend_reg;
        pend_last_next = pend_last_reg;
        out_valid_next = out_valid_reg;
        out_last_next  = out_last_reg;
        out_load       = pend_reg && out_free;

        if (cfg_valid)
        begin
            if (cfg_index == CFG_HALF_WIDTH)
            begin
                hw_next = cfg_data[HW_BITS-1:0];
            end
            else if (cfg_index == CFG_PASS_COUNT)
            begin
                pc_next = cfg_data[PC_BITS-1:0];
            end
        end

        if (load_wr)
        begin
            fill_next = fill_reg + 1'b1;
        end
        if (close_item)
        begin
            r_next      = r_eff;
            passes_next = pc_eff;
        end

        if (issue && (t_reg != t_last))
        begin
            t_next = t_reg + 1'b1;
        end
        if (state_reg == ST_DRAIN)
        begin
            drain_next = drain_reg + 1'b1;
            if (drain_end)
            begin
                drain_next  = '0;
                src_next    = !src_reg;
                passes_next = passes_reg - 1'b1;
            end
        end

        if (state_reg == ST_EMIT)
        begin
            e_next = e_reg + CNT_BITS'(e_issue);
            if ((e_reg == fill_reg) && !pend_reg)
            begin
                fill_next = '0;
            end
        end

        if (e_issue)
        begin
            pend_next      = 1'b1;
            pend_last_next = (e_reg == fill_reg - 1'b1);
        end
        else if (out_load)
        begin
            pend_next = 1'b0;
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_last_next  = pend_last_reg;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            hw_reg        <= HW_BITS'(1);
            pc_reg        <= PC_BITS'(1);
            fill_reg      <= '0;
            r_reg         <= HW_BITS'(1);
            passes_reg    <= '0;
            src_reg       <= 1'b0;
            t_reg         <= '0;
            drain_reg     <= '0;
            e_reg         <= '0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            step_reg      <= '0;
            for (int i = 0; i < PIPE_LAT; i++)
            begin
                emit_pipe_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            hw_reg        <= hw_next;
            pc_reg        <= pc_next;
            fill_reg      <= fill_next;
            r_reg         <= r_next;
            passes_reg    <= passes_next;
            src_reg       <= src_next;
            t_reg         <= t_next;
            drain_reg     <= drain_next;
            e_reg         <= e_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
            step_reg      <= step_next;
            emit_pipe_reg[0] <= emit_in;
            for (int i = 1; i < PIPE_LAT; i++)
            begin
                emit_pipe_reg[i] <= emit_pipe_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_pipe_reg[0] <= idx_in;
        for (int i = 1; i < PIPE_LAT; i++)
        begin
            idx_pipe_reg[i] <= idx_pipe_reg[i-1];
        end
        if (out_load)
        begin
            out_word_reg <= rd_a;
        end
    end

    // sample banks, ping-pong between passes
    always_ff @(posedge clk)
    begin
        if (wr0)
        begin
            mem0_reg[wr_addr] <= wr_data;
        end
        if (wr1)
        begin
            mem1_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            a0_reg <= mem0_reg[rd_addr_a];
            b0_reg <= mem0_reg[rd_addr_b];
            a1_reg <= mem1_reg[rd_addr_a];
            b1_reg <= mem1_reg[rd_addr_b];
        end
    end

    vtbs_recip #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_recip (
        .clk   (clk),
        .rst_n (rst_n),
        .start (close_item),
        .w     (w_eff),
        .busy  (recip_busy),
        .m     (recip_m)
    );

    vtbs_lane #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .clr      (clr),
        .step     (step_reg),
        .add_data (signed'(rd_a[SAMPLE_BITS-1:0])),
        .sub_data (signed'(rd_b[SAMPLE_BITS-1:0])),
        .w        (w_cur),
        .m        (recip_m),
        .q        (q_x)
    );

    vtbs_lane #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .clr      (clr),
        .step     (step_reg),
        .add_data (signed'(rd_a[2*SAMPLE_BITS-1:SAMPLE_BITS])),
        .sub_data (signed'(rd_b[2*SAMPLE_BITS-1:SAMPLE_BITS])),
        .w        (w_cur),
        .m        (recip_m),
        .q        (q_y)
    );

    vtbs_lane #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_z (
        .clk      (clk),
        .rst_n    (rst_n),
        .clr      (clr),
        .step     (step_reg),
        .add_data (signed'(rd_a[3*SAMPLE_BITS-1:2*SAMPLE_BITS])),
        .sub_data (signed'(rd_b[3*SAMPLE_BITS-1:2*SAMPLE_BITS])),
        .w        (w_cur),
        .m        (recip_m),
        .q        (q_z)
    );

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_last  = out_last_reg;
    assign out_x     = signed'(out_word_reg[SAMPLE_BITS-1:0]);
    assign out_y     = signed'(out_word_reg[2*SAMPLE_BITS-1:SAMPLE_BITS]);
    assign out_z     = signed'(out_word_reg[3*SAMPLE_BITS-1:2*SAMPLE_BITS]);

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import vtbs_pkg::*;

    localparam int SB          = SAMPLE_BITS_DEF;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int PHASE_ITEMS = 8;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [SB-1:0] x;
        logic [SB-1:0] y;
        logic [SB-1:0] z;
        logic          last;
    } entry_t;

    typedef struct {
        int x, y, z;
        bit last;
        bit typed;
        int ex, ey, ez;
    } row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    logic                    in_valid;
    logic                    in_stall;
    logic signed [SB-1:0]    in_x;
    logic signed [SB-1:0]    in_y;
    logic signed [SB-1:0]    in_z;
    logic                    in_last;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic signed [SB-1:0]    out_x;
    logic signed [SB-1:0]    out_y;
    logic signed [SB-1:0]    out_z;
    logic                    out_last;

    vector_table_box_smoother u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_x      (in_x),
        .in_y      (in_y),
        .in_z      (in_z),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_z     (out_z),
        .out_last  (out_last)
    );

    // shadow of the block: loaded samples and register copies
    int              samples [DEPTH_DEF][3];
    int              fill_n = 0;
    logic [HW_BITS-1:0] hw_set = 5'd1;
    logic [PC_BITS-1:0] pc_set = 4'd1;
    entry_t          smoothed_q [$];
    entry_t          want;

    int  n_errors   = 0;
    int  n_checked  = 0;
    int  n_samples  = 0;
    int  n_tables   = 0;
    int  n_settings = 0;
    int  cycle_n    = 0;
    int  stall_left = 0;
    bit  quiet      = 1'b0;

    row_t plan [20] = '{
        '{ 32767, -32768,      0, 1, 1,  32767, -32768,      0},
        '{    -1,      1, -32768, 1, 1,     -1,      1, -32768},
        '{-32768,  32767, -32768, 0, 0,      0,      0,      0},
        '{-32768,  32767, -32768, 0, 0,      0,      0,      0},
        '{-32768,  32767, -32768, 1, 1, -32768,  32767, -32768},
        '{    -1,      0,      1, 0, 0,      0,      0,      0},
        '{     0,     -1,     -2, 1, 0,      0,      0,      0},
        '{ 32767, -32768,  32767, 0, 0,      0,      0,      0},
        '{-32768,  32767, -32768, 0, 0,      0,      0,      0},
        '{ 32767,  32767, -32768, 0, 0,      0,      0,      0},
        '{-32768, -32768,  32767, 1, 0,      0,      0,      0},
        '{     0,    100,   -100, 0, 0,      0,      0,      0},
        '{     1,    200,   -200, 0, 0,      0,      0,      0},
        '{     2,    300,   -300, 0, 0,      0,      0,      0},
        '{     3,    400,   -400, 0, 0,      0,      0,      0},
        '{     4,    500,   -500, 1, 0,      0,      0,      0},
        '{     0,      0,      0, 1, 1,      0,      0,      0},
        '{     5,     -5,      7, 0, 0,      0,      0,      0},
        '{    -7,      3,     -2, 0, 0,      0,      0,      0},
        '{     1,      1,      1, 1, 0,      0,      0,      0}
    };

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int floor_div(int s, int w);
        int q;
        q = s / w;
        if ((s % w) != 0 && s < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    function automatic int pick_sample();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return $urandom_range(0, 1) ? 32767 : -32768;
        if (roll < 3)
            return $urandom_range(0, 8) - 4;
        return $urandom_range(0, 65535) - 32768;
    endfunction

    function automatic int table_len();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0)
            return $urandom_range(60, 68);
        if (roll < 4)
            return $urandom_range(9, 20);
        return $urandom_range(1, 8);
    endfunction

    task automatic report_mismatch(string what, int got, int exp_v);
        n_errors++;
        if (n_errors <= 50)
            $display("mismatch %s: got %0d expected %0d (cycle %0d)",
                     what, got, exp_v, cycle_n);
    endtask

    task automatic take_sample(int x, int y, int z);
        if (fill_n < DEPTH_DEF)
        begin
            samples[fill_n][0] = x;
            samples[fill_n][1] = y;
            samples[fill_n][2] = z;
            fill_n++;
        end
    endtask

    // closes the loaded table: either the typed constant or the box-average passes
    task automatic smooth_table(bit typed, int ex, int ey, int ez);
        int     r, passes, w, sum, idx;
        int     nxt [DEPTH_DEF][3];
        entry_t e;
        r      = (hw_set == 0) ? 1 : ((hw_set > RANGE_MAX_DEF) ? RANGE_MAX_DEF : hw_set);
        passes = (pc_set == 0) ? 1 : pc_set;
        w      = 2 * r + 1;
        if (!typed)
        begin
            for (int p = 0; p < passes; p++)
            begin
                for (int i = 0; i < fill_n; i++)
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        sum = 0;
                        for (int j = i - r; j <= i + r; j++)
                        begin
                            idx = (j < 0) ? 0 : ((j >= fill_n) ? fill_n - 1 : j);
                            sum += samples[idx][c];
                        end
                        nxt[i][c] = floor_div(sum, w);
                    end
                end
                for (int i = 0; i < fill_n; i++)
                    for (int c = 0; c < 3; c++)
                        samples[i][c] = nxt[i][c];
            end
        end
        for (int i = 0; i < fill_n; i++)
        begin
            e.x    = typed ? SB'(ex) : SB'(samples[i][0]);
            e.y    = typed ? SB'(ey) : SB'(samples[i][1]);
            e.z    = typed ? SB'(ez) : SB'(samples[i][2]);
            e.last = (i == fill_n - 1);
            smoothed_q.push_back(e);
        end
        fill_n = 0;
        n_tables++;
    endtask

    task automatic push_sample(int x, int y, int z, bit last);
        int gap;
        gap = quiet ? 0 : idle_len();
        @(negedge clk);
        repeat (gap)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_x     <= SB'(x);
        in_y     <= SB'(y);
        in_z     <= SB'(z);
        in_last  <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        n_samples++;
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_HALF_WIDTH: hw_set = data[HW_BITS-1:0];
            CFG_PASS_COUNT: pc_set = data[PC_BITS-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (smoothed_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 16) @(posedge clk);
        n_settings++;
    endtask

    task automatic run_phase(logic [CFG_DATA_BITS-1:0] hw, logic [CFG_DATA_BITS-1:0] pcd,
                             bit calm, bit big);
        int  sent, len, x, y, z;
        bit  last;
        sent = 0;
        write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, CFG_DATA_BITS'($urandom));
        write_reg(CFG_HALF_WIDTH, hw);
        write_reg(CFG_PASS_COUNT, pcd);
        quiet = calm;
        while (sent < PHASE_ITEMS || big)
        begin
            len = big ? DEPTH_DEF + 2 : table_len();
            big = 1'b0;
            for (int k = 0; k < len; k++)
            begin
                x    = pick_sample();
                y    = pick_sample();
                z    = pick_sample();
                last = (k == len - 1);
                push_sample(x, y, z, last);
                take_sample(x, y, z);
                if (last)
                    smooth_table(1'b0, 0, 0, 0);
                sent++;
            end
        end
        quiet = 1'b0;
        settle();
    endtask

    // output stall: short bursts, occasional long holds, long calm stretches
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            if (out_stall)
            begin
                out_stall  <= 1'b0;
                stall_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                          : $urandom_range(1, 20);
            end
            else
            begin
                out_stall  <= 1'b1;
                stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                          : $urandom_range(1, 3);
            end
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (smoothed_q.size() == 0)
            begin
                report_mismatch("unexpected item, x", out_x, 0);
            end
            else
            begin
                want = smoothed_q.pop_front();
                n_checked++;
                if (out_x !== want.x)
                    report_mismatch("x", out_x, $signed(want.x));
                if (out_y !== want.y)
                    report_mismatch("y", out_y, $signed(want.y));
                if (out_z !== want.z)
                    report_mismatch("z", out_z, $signed(want.z));
                if (out_last !== want.last)
                    report_mismatch("last", out_last, want.last);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_n++;
        if (cycle_n > CYCLE_LIMIT)
        begin
            $display("timeout with %0d entries outstanding", smoothed_q.size());
            $display("tb: errors");
            $finish;
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_HALF_WIDTH;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_x      = '0;
        in_y      = '0;
        in_z      = '0;
        in_last   = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed rows run on the reset register values
        for (int i = 0; i < 20; i++)
        begin
            push_sample(plan[i].x, plan[i].y, plan[i].z, plan[i].last);
            take_sample(plan[i].x, plan[i].y, plan[i].z);
            if (plan[i].last)
                smooth_table(plan[i].typed, plan[i].ex, plan[i].ey, plan[i].ez);
        end
        settle();

        run_phase(5'd0,  5'h00, 1'b0, 1'b0);
        run_phase(5'd31, 5'h0F, 1'b0, 1'b1);
        run_phase(5'd2,  5'h13, 1'b1, 1'b0);
        run_phase(5'd31, 5'h01, 1'b0, 1'b1);
        run_phase(5'd1,  5'h1F, 1'b0, 1'b0);
        run_phase(5'd5,  5'h02, 1'b0, 1'b0);
        run_phase(CFG_DATA_BITS'($urandom), CFG_DATA_BITS'($urandom), 1'b0, 1'b0);
        run_phase(CFG_DATA_BITS'($urandom), CFG_DATA_BITS'($urandom), 1'b1, 1'b0);

        $display("summary: %0d tables from %0d samples, %0d smoothed entries checked",
                 n_tables, n_samples, n_checked);
        $display("summary: %0d register settings incl. zero, max and overfull tables",
                 n_settings);
        if (n_errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
